// ===== hw/rtl/fwdmix_pkg.sv =====
package fwdmix_pkg;

    // field widths
    localparam int AXIS_W     = 11;
    localparam int TRIG_W     = 10;
    localparam int DUTY_OUT_W = 8;
    localparam int MAXD_W     = 8;
    localparam int STEP_W     = 8;
    localparam int DZ_W       = 10;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE  = 2'd2;

    localparam logic [MAXD_W-1:0] MAX_DUTY_RST  = 8'd255;
    localparam logic [STEP_W-1:0] RAMP_STEP_RST = 8'd5;
    localparam logic [DZ_W-1:0]   DEADZONE_RST  = 10'd20;

    // full-scale axis value is 2**AXIS_SHIFT
    localparam int AXIS_SHIFT = 9;

    localparam int DUTY_BITS_DEF = 8;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic [TRIG_W-1:0]        t_trig;
    typedef logic [DUTY_OUT_W-1:0]    t_duty;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]    t_cfg_data;

endpackage

// ===== hw/rtl/four_wheel_drive_mixer_ramp.sv =====
// Four-wheel joystick mixer with per-wheel slew limit.
//
// Input channel (i_in_valid / o_in_ready) carries one joystick sample: forward
// and turn axes plus the two trigger levels. Output channel (o_out_valid /
// i_out_ready) carries one result per sample: the four ramped wheel duties and
// the four direction bits.
//
// The datapath is four register stages: input, scaled axes, saturated targets,
// held duties. A result moves from the input register through each later stage
// in turn. A new sample is taken every cycle while the output is drained;
// throughput is one sample per cycle, since each stage reloads in the same
// cycle that its successor hands its sample on.
//
// When the receiver stalls the result and the held duties stay put; the earlier
// stages keep filling until each holds a sample, then o_in_ready drops.
//
// Configuration (max_duty, ramp_step, deadzone) is written via i_cfg_we,
// i_cfg_index, i_cfg_data; the user must write it only while no sample is in
// flight, not enforced by the block. Index 3 is ignored. Sync reset clears the
// pipeline, zeroes held duties, sets max_duty 255, ramp_step 5, deadzone 20.
module four_wheel_drive_mixer_ramp #(
    parameter int DUTY_BITS = fwdmix_pkg::DUTY_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_cfg_we,
    input  fwdmix_pkg::t_cfg_idx   i_cfg_index,
    input  fwdmix_pkg::t_cfg_data  i_cfg_data,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  fwdmix_pkg::t_axis      i_axis_forward,
    input  fwdmix_pkg::t_axis      i_axis_turn,
    input  fwdmix_pkg::t_trig      i_trigger_left,
    input  fwdmix_pkg::t_trig      i_trigger_right,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output fwdmix_pkg::t_duty      o_duty_one,
    output fwdmix_pkg::t_duty      o_duty_two,
    output fwdmix_pkg::t_duty      o_duty_three,
    output fwdmix_pkg::t_duty      o_duty_four,
    output logic                   o_dir_one,
    output logic                   o_dir_two,
    output logic                   o_dir_three,
    output logic                   o_dir_four
);
    import fwdmix_pkg::*;

    localparam int PROD_W   = AXIS_W + MAXD_W + 1;
    localparam int RAW_W    = AXIS_W + 2;
    localparam int SW       = ((DUTY_BITS > MAXD_W) ? DUTY_BITS : MAXD_W) + 1;
    localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;

    // configuration registers
    logic [MAXD_W-1:0] r_max_duty;
    logic [STEP_W-1:0] r_ramp_step;
    logic [DZ_W-1:0]   r_deadzone;

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    // stage 1: input sample
    t_axis r_fy, r_tx;
    t_trig r_tl, r_tr;

    // stage 2: scaled axes and rotation
    t_axis n_fy_dz, n_tx_dz;
    t_axis n_fwd, n_trn, n_rot;
    logic  n_straight;
    t_axis r_fwd, r_trn, r_rot;
    logic  r_straight;

    // stage 3: saturated targets and directions
    logic signed [RAW_W-1:0] n_raw [4];
    logic [RAW_W-1:0]        w_mag [4];
    logic [MAXD_W-1:0]       w_lim;
    logic [MAXD_W-1:0]       w_sat [4];
    logic [MAXD_W-1:0]       w_best01, w_best23, w_best;
    logic [MAXD_W-1:0]       n_tgt [4];
    logic [3:0]              n_dir;
    logic [MAXD_W-1:0]       r_tgt [4];
    logic [3:0]              r_dir_s3;

    // stage 4: held duties (also the output register)
    logic [DUTY_BITS-1:0] r_held [4];
    logic [DUTY_BITS-1:0] n_held [4];
    logic [3:0]           r_dir;
    logic [SW-1:0]        w_cur, w_tgt, w_stp, w_nxt;
    logic [3:0]           w_step_ok;

    function automatic t_axis apply_deadzone(input t_axis a, input logic [DZ_W-1:0] dz);
        logic [AXIS_W-1:0] mag;
        mag = a[AXIS_W-1] ? AXIS_W'(~a + 1'b1) : AXIS_W'(a);
        return (mag < AXIS_W'(dz)) ? '0 : a;
    endfunction

    // a * md / 512 truncated toward zero: bias negatives by 511 before the shift
    function automatic t_axis scale_axis(input t_axis a, input logic [MAXD_W-1:0] md);
        logic signed [PROD_W-1:0] p;
        logic [PROD_W-1:0]        b;
        p = PROD_W'(a) * PROD_W'($signed({1'b0, md}));
        b = PROD_W'(unsigned'(p)) + PROD_W'({AXIS_SHIFT{p[PROD_W-1]}});
        return $signed(b[PROD_W-1:AXIS_SHIFT]);
    endfunction

    // handshake chain
    assign w_en4      = !r_v4 || i_out_ready;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_duty  <= MAX_DUTY_RST;
            r_ramp_step <= RAMP_STEP_RST;
            r_deadzone  <= DEADZONE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_DUTY:  r_max_duty  <= i_cfg_data[MAXD_W-1:0];
                REG_RAMP_STEP: r_ramp_step <= i_cfg_data[STEP_W-1:0];
                REG_DEADZONE:  r_deadzone  <= i_cfg_data[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_en1 && i_in_valid) begin
            r_fy <= i_axis_forward;
            r_tx <= i_axis_turn;
            r_tl <= i_trigger_left;
            r_tr <= i_trigger_right;
        end
    end

    // stage 2
    always_comb begin
        n_fy_dz    = apply_deadzone(r_fy, r_deadzone);
        n_tx_dz    = apply_deadzone(r_tx, r_deadzone);
        n_fwd      = scale_axis(n_fy_dz, r_max_duty);
        n_trn      = scale_axis(n_tx_dz, r_max_duty);
        n_rot      = $signed(AXIS_W'(r_tr) - AXIS_W'(r_tl));
        n_straight = (n_tx_dz == '0) && (n_rot == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_fwd      <= n_fwd;
            r_trn      <= n_trn;
            r_rot      <= n_rot;
            r_straight <= n_straight;
        end
    end

    // stage 3
    always_comb begin
        n_raw[0] = -RAW_W'(r_fwd) + RAW_W'(r_trn) + RAW_W'(r_rot);
        n_raw[1] = -RAW_W'(r_fwd) - RAW_W'(r_trn) - RAW_W'(r_rot);
        n_raw[2] =  RAW_W'(r_fwd) - RAW_W'(r_trn) + RAW_W'(r_rot);
        n_raw[3] =  RAW_W'(r_fwd) + RAW_W'(r_trn) - RAW_W'(r_rot);

        // a narrow held duty also caps the target
        w_lim = r_max_duty;
        if (DUTY_BITS < MAXD_W && r_max_duty > MAXD_W'(DUTY_MAX)) begin
            w_lim = MAXD_W'(DUTY_MAX);
        end

        for (int i = 0; i < 4; i++) begin
            w_mag[i] = n_raw[i][RAW_W-1] ? RAW_W'(-n_raw[i]) : RAW_W'(n_raw[i]);
            w_sat[i] = (w_mag[i] > RAW_W'(w_lim)) ? w_lim : w_mag[i][MAXD_W-1:0];
        end

        w_best01 = (w_sat[1] > w_sat[0]) ? w_sat[1] : w_sat[0];
        w_best23 = (w_sat[3] > w_sat[2]) ? w_sat[3] : w_sat[2];
        w_best   = (w_best23 > w_best01) ? w_best23 : w_best01;

        for (int i = 0; i < 4; i++) begin
            n_tgt[i] = r_straight ? w_best : w_sat[i];
        end

        n_dir[0] = !n_raw[0][RAW_W-1] && (n_raw[0] != '0);
        n_dir[1] = !n_raw[1][RAW_W-1] && (n_raw[1] != '0);
        n_dir[2] = n_raw[2][RAW_W-1];
        n_dir[3] = n_raw[3][RAW_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en3 && r_v2) begin
            r_tgt    <= n_tgt;
            r_dir_s3 <= n_dir;
        end
    end

    // stage 4: slew each held duty toward its target
    always_comb begin
        w_cur     = '0;
        w_tgt     = '0;
        w_nxt     = '0;
        w_stp     = SW'(r_ramp_step);
        w_step_ok = '0;
        for (int i = 0; i < 4; i++) begin
            w_cur = SW'(r_held[i]);
            w_tgt = SW'(r_tgt[i]);
            if (w_cur < w_tgt) begin
                w_nxt = (w_tgt - w_cur <= w_stp) ? w_tgt : w_cur + w_stp;
            end else if (w_cur > w_tgt) begin
                w_nxt = (w_cur - w_tgt <= w_stp) ? w_tgt : w_cur - w_stp;
            end else begin
                w_nxt = w_cur;
            end
            n_held[i]    = DUTY_BITS'(w_nxt);
            w_step_ok[i] = (w_nxt + w_stp >= w_cur) && (w_nxt <= w_cur + w_stp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= '0;
            end
        end else if (w_en4 && r_v3) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4 && r_v3) begin
            r_dir <= r_dir_s3;
        end
    end

    assign o_out_valid  = r_v4;
    assign o_duty_one   = DUTY_OUT_W'(r_held[0]);
    assign o_duty_two   = DUTY_OUT_W'(r_held[1]);
    assign o_duty_three = DUTY_OUT_W'(r_held[2]);
    assign o_duty_four  = DUTY_OUT_W'(r_held[3]);
    assign o_dir_one    = r_dir[0];
    assign o_dir_two    = r_dir[1];
    assign o_dir_three  = r_dir[2];
    assign o_dir_four   = r_dir[3];

    // an input transfer always lands in stage 1
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v1)
        else $error("input transfer lost at stage 1");

    // held duties move only when a result is loaded
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_en4 && r_v3) |=> ($stable(r_held[0]) && $stable(r_held[1])
                              && $stable(r_held[2]) && $stable(r_held[3])))
        else $error("held duty changed without a result load");

    // no wheel moves by more than ramp_step per sample
    a_slew_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en4 && r_v3) |-> (w_step_ok == 4'b1111))
        else $error("held duty step exceeds ramp_step");

    // straight-line samples give one common target
    a_straight_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en3 && r_v2 && r_straight) |=> ((r_tgt[0] == r_tgt[1])
                                           && (r_tgt[1] == r_tgt[2])
                                           && (r_tgt[2] == r_tgt[3])))
        else $error("straight-line targets differ");

endmodule
